[hw/rtl/rgcd_pkg.sv]
package rgcd_pkg;

  // Default operand width of the block.
  localparam int unsigned VALUE_BITS_DEF = 31;

  // Sequencer of the shared binary GCD unit.
  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_STEP,
    CORE_SHIFT
  } rgcd_core_e;

  // Top level control: waiting for a transaction, waiting for the unit,
  // or holding a finished sequence result until the output slot is free.
  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_CALC,
    TOP_HOLD
  } rgcd_top_e;

  // Status that the GCD unit reports to its controller.
  typedef struct packed {
    logic busy;
    logic done;
  } rgcd_stat_t;

endpackage

[hw/rtl/rgcd_core.sv]
module rgcd_core import rgcd_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [VALUE_BITS-1:0] a_i,
  input  logic [VALUE_BITS-1:0] b_i,
  output rgcd_stat_t            stat_o,
  output logic [VALUE_BITS-1:0] result_o
);

  localparam int unsigned KW = $clog2(VALUE_BITS);

  rgcd_core_e            state_q, state_d;
  logic [VALUE_BITS-1:0] a_q, a_d;
  logic [VALUE_BITS-1:0] b_q, b_d;
  logic [KW-1:0]         k_q, k_d;
  logic [VALUE_BITS-1:0] res_q, res_d;
  logic                  done_q, done_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CORE_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    k_q   <= k_d;
    res_q <= res_d;
  end

  // Binary GCD: strip common factors of two into k, drop single factors
  // of two, subtract the smaller odd operand from the larger one.
  always_comb begin
    state_d = state_q;
    a_d     = a_q;
    b_d     = b_q;
    k_d     = k_q;
    res_d   = res_q;
    done_d  = 1'b0;
    case (state_q)
      CORE_IDLE: begin
        if (start_i) begin
          a_d     = a_i;
          b_d     = b_i;
          k_d     = '0;
          state_d = CORE_STEP;
        end
      end
      CORE_STEP: begin
        if (a_q == '0) begin
          a_d     = b_q;
          state_d = CORE_SHIFT;
        end else if (b_q == '0) begin
          state_d = CORE_SHIFT;
        end else if (!a_q[0] && !b_q[0]) begin
          a_d = a_q >> 1;
          b_d = b_q >> 1;
          k_d = k_q + KW'(1);
        end else if (!a_q[0]) begin
          a_d = a_q >> 1;
        end else if (!b_q[0]) begin
          b_d = b_q >> 1;
        end else if (a_q >= b_q) begin
          a_d = a_q - b_q;
        end else begin
          b_d = b_q - a_q;
        end
      end
      CORE_SHIFT: begin
        res_d   = a_q << k_q;
        done_d  = 1'b1;
        state_d = CORE_IDLE;
      end
      default: state_d = CORE_IDLE;
    endcase
  end

  assign stat_o.busy = (state_q != CORE_IDLE);
  assign stat_o.done = done_q;
  assign result_o    = res_q;

endmodule

[hw/rtl/running_gcd_of_sequence.sv]
// Running greatest common divisor over a sequence of unsigned integers.
//
// Input channel (in_valid_i / in_ready_o): one transaction carries one
// element value_i and the flag last_element_i that marks the end of a
// sequence. Output channel (out_valid_o / out_ready_i): one transaction
// carries gcd_result_o, the GCD of every element of the sequence that just
// ended. Only the last element of a sequence produces an output transaction.
//
// Each element is folded into the running value by one shared binary GCD
// unit that takes one shift or one subtract per cycle. How long an element
// takes from acceptance until the block is ready again is set by the step
// count of the subtract/shift loop, so it is shortest when the running value
// or the element is zero. The block accepts no new element while the unit
// works.
//
// Reset clears the running value to zero and empties the output register.
// A finished result waits in the output register while the receiver stalls,
// and the next sequence may already start meanwhile. Only when a second
// result finishes while the first still waits does the block hold off its
// input until the output register frees.
module running_gcd_of_sequence import rgcd_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  last_element_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [VALUE_BITS-1:0] gcd_result_o
);

  rgcd_top_e             state_q, state_d;
  logic [VALUE_BITS-1:0] running_q, running_d;
  logic                  last_q, last_d;
  logic                  out_valid_q, out_valid_d;
  logic [VALUE_BITS-1:0] out_data_q, out_data_d;
  logic                  start;
  rgcd_stat_t            core_stat;
  logic [VALUE_BITS-1:0] core_result;
  logic                  out_free;

  rgcd_core #(
    .VALUE_BITS(VALUE_BITS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .a_i     (running_q),
    .b_i     (value_i),
    .stat_o  (core_stat),
    .result_o(core_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= TOP_IDLE;
      running_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      running_q   <= running_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q     <= last_d;
    out_data_q <= out_data_d;
  end

  // The output register can take a new result when it is empty or when its
  // current transaction completes in this cycle.
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    running_d   = running_q;
    last_d      = last_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !out_ready_i;
    start       = 1'b0;
    in_ready_o  = 1'b0;
    case (state_q)
      TOP_IDLE: begin
        in_ready_o = !core_stat.busy;
        if (in_valid_i && !core_stat.busy) begin
          start   = 1'b1;
          last_d  = last_element_i;
          state_d = TOP_CALC;
        end
      end
      TOP_CALC: begin
        if (core_stat.done) begin
          if (!last_q) begin
            // Middle of a sequence: the result becomes the running value.
            running_d = core_result;
            state_d   = TOP_IDLE;
          end else if (out_free) begin
            out_data_d  = core_result;
            out_valid_d = 1'b1;
            running_d   = '0;
            state_d     = TOP_IDLE;
          end else begin
            state_d = TOP_HOLD;
          end
        end
      end
      TOP_HOLD: begin
        // The unit keeps its result stable until the next start.
        if (out_free) begin
          out_data_d  = core_result;
          out_valid_d = 1'b1;
          running_d   = '0;
          state_d     = TOP_IDLE;
        end
      end
      default: state_d = TOP_IDLE;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign gcd_result_o = out_data_q;

endmodule

[verif/running_gcd_of_sequence_test.sv]
module running_gcd_of_sequence_test;
  timeunit 1ns;
  timeprecision 1ps;

  // The operand width comes from the package so that the testbench follows the
  // default build of the block.
  localparam int unsigned VW = rgcd_pkg::VALUE_BITS_DEF;
  localparam longint unsigned VMAX = (longint'(1) << VW) - 1;

  // The run is cut off after this many cycles.
  localparam int unsigned CYCLE_LIMIT = 1000000;

  // The receiver stops taking results once, for this many cycles, after this
  // many results have come. The sender keeps offering elements meanwhile, so
  // the block fills its output register and then holds off its input.
  localparam int unsigned STALL_AFTER = 40;
  localparam int unsigned STALL_CYCLES = 2000;

  // Cycles allowed after the last expected result before the verdict. This
  // covers the slowest single fold with margin.
  localparam int unsigned SETTLE_CYCLES = 200;

  typedef logic [VW-1:0] value_t;

  typedef struct packed {
    value_t value;
    logic   last;
  } element_t;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   in_valid_i = 1'b0;
  logic   in_ready_o;
  value_t value_i = '0;
  logic   last_element_i = 1'b0;
  logic   out_valid_o;
  logic   out_ready_i = 1'b0;
  value_t gcd_result_o;

  // Elements waiting to be offered, and GCDs of finished sequences waiting to
  // come out of the block, oldest first.
  element_t    element_q[$];
  value_t      gcd_expected_q[$];

  // GCD of the elements accepted so far in the current sequence.
  value_t      seq_gcd_q = '0;

  int unsigned send_idle_pct = 28;
  int unsigned recv_idle_pct = 28;
  int unsigned err_cnt = 0;
  int unsigned result_cnt = 0;
  int unsigned stall_left = 0;
  logic        stall_done = 1'b0;
  int unsigned cycle_cnt = 0;

  running_gcd_of_sequence i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .value_i        (value_i),
    .last_element_i (last_element_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .gcd_result_o   (gcd_result_o)
  );

  always #10 clk_i = ~clk_i;

  // Plain Euclid on two operands. gcd(0, x) = x falls out of the loop, since a
  // zero second operand ends it at once and a zero first operand swaps in.
  function automatic value_t gcd_of_pair(value_t a, value_t b);
    value_t r;
    while (b != '0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  task automatic add_element(input longint unsigned v, input logic last);
    element_t e;
    e.value = value_t'(v);
    e.last  = last;
    element_q.push_back(e);
  endtask

  // Builds random sequences until about n_items elements are queued. Most of
  // them share a common factor so that the GCDs come out interesting instead
  // of nearly always 1. A tenth is noise with a random end flag on every
  // element, which cuts sequences at arbitrary points.
  task automatic add_random_sequences(input int unsigned n_items);
    int unsigned     count;
    int unsigned     len;
    int unsigned     kind;
    longint unsigned g;
    longint unsigned v;
    logic            last;
    count = 0;
    while (count < n_items) begin
      kind = $urandom_range(9);
      len  = ($urandom_range(7) == 0) ? $urandom_range(12, 1) : $urandom_range(5, 1);
      case (kind)
        0, 1, 2, 3: begin
          g = $urandom_range(1000, 1);
        end
        4: begin
          g = longint'(1) << $urandom_range(VW - 1);
        end
        5, 6: begin
          g = $urandom_range(32'h4000_0000, 32'h0001_0000);
        end
        default: begin
          g = 1;
        end
      endcase
      for (int unsigned k = 0; k < len; k++) begin
        if (kind >= 7) begin
          v = $urandom() & VMAX;
        end else begin
          v = longint'($urandom_range(int'(VMAX / g))) * g;
        end
        // Zero elements must leave the running value alone.
        if (kind == 8 && $urandom_range(3) == 0) begin
          v = 0;
        end
        last = (k == len - 1);
        if (kind == 9) begin
          last = $urandom_range(1);
        end
        add_element(v, last);
      end
      count += len;
    end
  endtask

  // The sender stands still until every queued element has been taken and
  // every expected result has come back.
  task automatic wait_drained();
    while (element_q.size() != 0 || in_valid_i || gcd_expected_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Driver. An element leaves the queue only when the input slot is free,
  // that is, when nothing is offered or the offered element is taken at this
  // edge. An offered element therefore stays put until its transaction. The
  // prediction is updated with the payload that was actually accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      value_i        <= '0;
      last_element_i <= 1'b0;
      seq_gcd_q      <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        if (last_element_i) begin
          gcd_expected_q.push_back(gcd_of_pair(seq_gcd_q, value_i));
          seq_gcd_q <= '0;
        end else begin
          seq_gcd_q <= gcd_of_pair(seq_gcd_q, value_i);
        end
      end
      if (!in_valid_i || in_ready_o) begin
        if (element_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i     <= 1'b1;
          value_i        <= element_q[0].value;
          last_element_i <= element_q[0].last;
          void'(element_q.pop_front());
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor. Every output transaction is matched against the oldest expected
  // GCD. The ready line is randomized each cycle, apart from the one long
  // hold-off that is counted down here.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  <= 0;
      stall_done  <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        result_cnt++;
        if (gcd_expected_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result, expected none, actual gcd_result %0d",
                   $realtime, gcd_result_o);
        end else begin
          if (gcd_result_o !== gcd_expected_q[0]) begin
            err_cnt++;
            $display("%0t: gcd_result mismatch, expected %0d, actual %0d",
                     $realtime, gcd_expected_q[0], gcd_result_o);
          end
          void'(gcd_expected_q.pop_front());
        end
      end
      if (stall_left != 0) begin
        stall_left  <= stall_left - 1;
        out_ready_i <= 1'b0;
      end else if (!stall_done && result_cnt >= STALL_AFTER) begin
        stall_left  <= STALL_CYCLES;
        stall_done  <= 1'b1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog. A hang anywhere ends the run here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles, %0d results still expected",
               $realtime, CYCLE_LIMIT, gcd_expected_q.size());
      $display("** running_gcd_of_sequence: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed sequences. These cover the field extremes, a lone zero, all
    // zeros, zeros mixed into a sequence, single-element sequences, powers
    // of two that exercise the shift path, and coprime and divisible pairs.
    add_element(0, 1'b1);
    add_element(VMAX, 1'b1);
    add_element(1, 1'b1);
    add_element(0, 1'b0);
    add_element(0, 1'b0);
    add_element(0, 1'b1);
    add_element(0, 1'b0);
    add_element(12, 1'b0);
    add_element(0, 1'b0);
    add_element(18, 1'b1);
    add_element(VMAX, 1'b0);
    add_element(longint'(1) << (VW - 1), 1'b1);
    add_element(longint'(1) << (VW - 1), 1'b0);
    add_element(longint'(1) << (VW - 2), 1'b1);
    add_element(1071, 1'b0);
    add_element(462, 1'b1);
    add_element(7, 1'b0);
    add_element(5, 1'b1);
    add_element(VMAX - 1, 1'b0);
    add_element(VMAX >> 1, 1'b1);
    wait_drained();

    // Random traffic with idling on both sides. The receiver's long
    // hold-off falls into this phase while the sender keeps going.
    add_random_sequences(500);
    wait_drained();

    // A long stretch in which neither side ever idles.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random_sequences(500);
    wait_drained();

    send_idle_pct = 28;
    recv_idle_pct = 28;
    add_random_sequences(750);
    wait_drained();

    // Anything that shows up now is an extra result and is flagged by the
    // monitor.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (gcd_expected_q.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d expected results never arrived", $realtime, gcd_expected_q.size());
    end
    if (err_cnt == 0) begin
      $display("** running_gcd_of_sequence: PASSED **");
    end else begin
      $display("** running_gcd_of_sequence: FAILED **");
    end
    $finish;
  end

endmodule

[running_gcd_of_sequence.f]
hw/rtl/rgcd_pkg.sv
hw/rtl/rgcd_core.sv
hw/rtl/running_gcd_of_sequence.sv
verif/running_gcd_of_sequence_test.sv
